// ===== rtl/rbth_pkg.sv =====
// Shared types, constants and helpers for the ROI band threshold histogram.
// No dependencies; every other file in rtl/ but rbth_ram uses this package.
package rbth_pkg;

    localparam int COUNT_BITS    = 24;
    localparam int COORD_BITS    = 12;
    localparam int SIZE_BITS     = COORD_BITS + 1;
    localparam int PIX_BITS      = 8;
    localparam int BIN_BITS      = 8;
    localparam int NUM_BINS      = 1 << BIN_BITS;
    localparam int FIELD_BITS    = 24;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = SIZE_BITS;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_BITS    = $clog2(Q_DEPTH);

    localparam logic [PIX_BITS-1:0] PIX_MAX = {PIX_BITS{1'b1}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BAND_LOW      = 3'd0,
        CFG_BAND_HIGH     = 3'd1,
        CFG_MARK_ENABLE   = 3'd2,
        CFG_REGION_ENABLE = 3'd3,
        CFG_REGION_X      = 3'd4,
        CFG_REGION_Y      = 3'd5,
        CFG_REGION_WIDTH  = 3'd6,
        CFG_REGION_HEIGHT = 3'd7
    } t_cfg_idx;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic [CFG_IDX_BITS-1:0]  index;
        logic [CFG_DATA_BITS-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [PIX_BITS-1:0]   band_low;
        logic [PIX_BITS-1:0]   band_high;
        logic                  mark_enable;
        logic                  region_enable;
        logic [COORD_BITS-1:0] region_x;
        logic [COORD_BITS-1:0] region_y;
        logic [SIZE_BITS-1:0]  region_width;
        logic [SIZE_BITS-1:0]  region_height;
    } t_cfg;

    typedef struct packed {
        logic                  opcode;
        logic [PIX_BITS-1:0]   gray_level;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  frame_start;
        logic [BIN_BITS-1:0]   bin_index;
    } t_pix;

    typedef struct packed {
        logic [PIX_BITS-1:0]   red_out;
        logic [PIX_BITS-1:0]   green_out;
        logic [PIX_BITS-1:0]   blue_out;
        logic                  marked;
        logic [FIELD_BITS-1:0] bin_count;
        logic [FIELD_BITS-1:0] peak_count;
    } t_res;

    // classified item passed from the front end to the histogram back end
    typedef struct packed {
        logic                op;
        logic                hit;
        logic                clr;
        logic [PIX_BITS-1:0] gray;
        logic [BIN_BITS-1:0] addr;
    } t_work;

    typedef struct packed {
        logic  push;
        t_work item;
    } t_push;

    typedef struct packed {
        logic  empty;
        t_work head;
    } t_qhead;

    function automatic logic [FIELD_BITS-1:0] f_clamp(input logic [COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        if (w > 32'((1 << FIELD_BITS) - 1))
            return {FIELD_BITS{1'b1}};
        return w[FIELD_BITS-1:0];
    endfunction

endpackage

// ===== rtl/rbth_ifs.sv =====
// Valid/ready channel interfaces: pixel input, result output, config write.
// Depends on rbth_pkg.
interface rbth_pix_if;
    logic             valid;
    logic             ready;
    rbth_pkg::t_pix   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbth_res_if;
    logic             valid;
    logic             ready;
    rbth_pkg::t_res   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbth_cfg_if;
    logic              valid;
    logic              ready;
    rbth_pkg::t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/roi_band_threshold_histogram.sv =====
// Top level of the ROI band threshold histogram: front end, queue and back end.
// Depends on rbth_pkg, rbth_ifs, rbth_front, rbth_queue, rbth_back and rbth_ram.
//
// Usage:
//   i_pix carries pixel items (opcode 0) and bin reads (opcode 1); o_res returns
//   exactly one result per item, in order. i_cfg writes the eight registers by
//   index and is always ready; write it only while no item is in flight.
//   A pixel in the band and in the region (when marking is on) comes out pure
//   red and bumps its histogram bin; other pixels pass through as gray. A pixel
//   with frame_start set clears all bins and the peak before it is counted.
// Timing:
//   One item per clock sustained while o_res is ready. A result passes through
//   the queue and the registered histogram RAM read, then the count update lands
//   in the output register. The RAM read of the next item overlaps the write of
//   the previous one and is forwarded.
// Reset:
//   Synchronous, active low. Registers take their defaults and the histogram
//   reads as zero at once (per-bin valid flags), so no clearing pass is needed.
// Backpressure:
//   When o_res stalls, the back end holds and the 4-entry queue fills; i_pix
//   drops ready only once the queue is full.
module roi_band_threshold_histogram (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rbth_cfg_if.sink   i_cfg,
    rbth_pix_if.sink   i_pix,
    rbth_res_if.source o_res
);
    import rbth_pkg::*;

    t_push  push;
    t_qhead qhead;
    logic   q_full;
    logic   q_pop;

    rbth_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_pix   (i_pix),
        .i_full  (q_full),
        .o_push  (push)
    );

    rbth_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_head  (qhead)
    );

    rbth_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (qhead),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );
endmodule

// ===== rtl/rbth_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rbth_front.sv =====
// Front end: config registers, input handshake and band/region classification.
// Depends on rbth_pkg and rbth_ifs.
module rbth_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rbth_cfg_if.sink          i_cfg,
    rbth_pix_if.sink          i_pix,
    input  logic              i_full,
    output rbth_pkg::t_push   o_push
);
    import rbth_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic                  in_band;
    logic                  in_col;
    logic                  in_row;
    logic                  in_region;
    logic [COORD_BITS+1:0] col_end;
    logic [COORD_BITS+1:0] row_end;
    t_pix                  pix;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.data.index))
                CFG_BAND_LOW:      n_cfg.band_low      = i_cfg.data.data[PIX_BITS-1:0];
                CFG_BAND_HIGH:     n_cfg.band_high     = i_cfg.data.data[PIX_BITS-1:0];
                CFG_MARK_ENABLE:   n_cfg.mark_enable   = i_cfg.data.data[0];
                CFG_REGION_ENABLE: n_cfg.region_enable = i_cfg.data.data[0];
                CFG_REGION_X:      n_cfg.region_x      = i_cfg.data.data[COORD_BITS-1:0];
                CFG_REGION_Y:      n_cfg.region_y      = i_cfg.data.data[COORD_BITS-1:0];
                CFG_REGION_WIDTH:  n_cfg.region_width  = i_cfg.data.data[SIZE_BITS-1:0];
                CFG_REGION_HEIGHT: n_cfg.region_height = i_cfg.data.data[SIZE_BITS-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.band_low      <= PIX_BITS'(128);
            r_cfg.band_high     <= PIX_MAX;
            r_cfg.mark_enable   <= 1'b0;
            r_cfg.region_enable <= 1'b0;
            r_cfg.region_x      <= '0;
            r_cfg.region_y      <= '0;
            r_cfg.region_width  <= SIZE_BITS'(500);
            r_cfg.region_height <= SIZE_BITS'(500);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign pix = i_pix.data;

    // region end is exclusive and may run past the last coordinate
    assign col_end = {2'b00, r_cfg.region_x} + {1'b0, r_cfg.region_width};
    assign row_end = {2'b00, r_cfg.region_y} + {1'b0, r_cfg.region_height};

    assign in_band   = (pix.gray_level >= r_cfg.band_low) && (pix.gray_level <= r_cfg.band_high);
    assign in_col    = (pix.column >= r_cfg.region_x) && ({2'b00, pix.column} < col_end);
    assign in_row    = (pix.row >= r_cfg.region_y) && ({2'b00, pix.row} < row_end);
    assign in_region = !r_cfg.region_enable || (in_col && in_row);

    assign i_pix.ready = !i_full;

    always_comb begin
        o_push.push      = i_pix.valid && !i_full;
        o_push.item.op   = pix.opcode;
        o_push.item.hit  = (pix.opcode == OP_PIXEL) && r_cfg.mark_enable && in_band && in_region;
        o_push.item.clr  = (pix.opcode == OP_PIXEL) && pix.frame_start;
        o_push.item.gray = pix.gray_level;
        o_push.item.addr = (pix.opcode == OP_READ) ? pix.bin_index : pix.gray_level;
    end
endmodule

// ===== rtl/rbth_queue.sv =====
// Small FIFO of classified items between front end and back end.
// Depends on rbth_pkg.
module rbth_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbth_pkg::t_push   i_push,
    input  logic              i_pop,
    output logic              o_full,
    output rbth_pkg::t_qhead  o_head
);
    import rbth_pkg::*;

    t_work                 r_slot [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wptr;
    logic [Q_PTR_BITS-1:0] r_rptr;
    logic [Q_PTR_BITS:0]   r_count;
    logic                  do_pop;

    assign do_pop = i_pop && (r_count != '0);
    assign o_full = (r_count == (Q_PTR_BITS+1)'(Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot[r_wptr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push.push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (Q_PTR_BITS+1)'(i_push.push) - (Q_PTR_BITS+1)'(do_pop);
        end
    end

    assign o_head.empty = (r_count == '0);
    assign o_head.head  = r_slot[r_rptr];
endmodule

// ===== rtl/rbth_back.sv =====
// Back end: histogram read-modify-write with forwarding, peak tracking, result register.
// Depends on rbth_pkg, rbth_ifs and rbth_ram.
module rbth_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rbth_pkg::t_qhead  i_head,
    output logic              o_pop,
    rbth_res_if.source        o_res
);
    import rbth_pkg::*;

    logic                  r_b1_v;
    t_work                 r_b1;
    logic                  r_out_v;
    t_res                  r_out;
    logic                  r_fw_v;
    logic [BIN_BITS-1:0]   r_fw_addr;
    logic [COUNT_BITS-1:0] r_fw_data;
    logic [NUM_BINS-1:0]   r_valid;
    logic [NUM_BINS-1:0]   n_valid;
    logic [COUNT_BITS-1:0] r_peak;

    logic [COUNT_BITS-1:0] ram_q;
    logic [COUNT_BITS-1:0] base;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [COUNT_BITS-1:0] peak_base;
    logic [COUNT_BITS-1:0] peak_new;
    logic                  b1_adv;
    logic                  load;
    logic                  wr_en;
    t_res                  res;

    assign b1_adv = r_b1_v && (!r_out_v || o_res.ready);
    assign load   = !i_head.empty && (!r_b1_v || b1_adv);
    assign o_pop  = load;
    assign wr_en  = b1_adv && r_b1.hit;

    rbth_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_b1.addr),
        .i_wdata (inc_cnt),
        .i_re    (load),
        .i_raddr (i_head.head.addr),
        .o_rdata (ram_q)
    );

    // the last write may have landed on the same edge as this item's read
    always_comb begin
        if (r_fw_v && (r_fw_addr == r_b1.addr))
            base = r_fw_data;
        else if (r_valid[r_b1.addr])
            base = ram_q;
        else
            base = '0;
        old_cnt   = r_b1.clr ? '0 : base;
        inc_cnt   = (&old_cnt) ? old_cnt : old_cnt + 1'b1;
        peak_base = r_b1.clr ? '0 : r_peak;
        peak_new  = (r_b1.hit && (inc_cnt > peak_base)) ? inc_cnt : peak_base;
    end

    always_comb begin
        n_valid = r_valid;
        if (r_b1.clr) begin
            n_valid = '0;
        end
        if (r_b1.hit) begin
            n_valid[r_b1.addr] = 1'b1;
        end
    end

    always_comb begin
        res = '0;
        if (r_b1.op == OP_READ) begin
            res.bin_count  = f_clamp(base);
            res.peak_count = f_clamp(r_peak);
        end else begin
            res.peak_count = f_clamp(peak_new);
            if (r_b1.hit) begin
                res.red_out = PIX_MAX;
                res.marked  = 1'b1;
            end else begin
                res.red_out   = r_b1.gray;
                res.green_out = r_b1.gray;
                res.blue_out  = r_b1.gray;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b1 <= i_head.head;
        end
        if (b1_adv) begin
            r_out     <= res;
            r_fw_addr <= r_b1.addr;
            r_fw_data <= inc_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_fw_v  <= 1'b0;
            r_valid <= '0;
            r_peak  <= '0;
        end else begin
            if (load) begin
                r_b1_v <= 1'b1;
            end else if (b1_adv) begin
                r_b1_v <= 1'b0;
            end
            if (b1_adv) begin
                r_out_v <= 1'b1;
            end else if (o_res.ready) begin
                r_out_v <= 1'b0;
            end
            if (b1_adv) begin
                r_fw_v  <= r_b1.hit;
                r_valid <= n_valid;
                if (r_b1.op == OP_PIXEL) begin
                    r_peak <= peak_new;
                end
            end
        end
    end

    assign o_res.valid = r_out_v;
    assign o_res.data  = r_out;
endmodule

// ===== test/roi_band_threshold_histogram_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for roi_band_threshold_histogram: directed table, then random frames.
// Depends on rbth_pkg, the rbth_*_if interfaces and the block's RTL.

module roi_band_threshold_histogram_test;
    import rbth_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 205;

    typedef struct {
        logic     is_reg;
        t_cfg_idx reg_idx;
        int       reg_val;
        t_pix     item;
        logic     typed;
        t_res     want;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic steady;
    logic pin_flag;
    t_res pin_res;

    rbth_cfg_if cfg_ch ();
    rbth_pix_if pix_ch ();
    rbth_res_if res_ch ();

    roi_band_threshold_histogram dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the block: registers, bins and peak
    t_cfg                  band_cfg;
    logic [COUNT_BITS-1:0] bin_tally [NUM_BINS];
    logic [COUNT_BITS-1:0] peak_tally;
    t_res                  rgb_due [$];

    t_step plan [$];
    int    cycle_count    = 0;
    int    mismatch_count = 0;
    int    results_seen   = 0;
    int    items_seen     = 0;
    int    reads_seen     = 0;
    int    marks_seen     = 0;
    int    settings_used  = 0;
    int    top_peak       = 0;
    int    frame_x0, frame_y0, frame_w, frame_pix, frame_left, hot_gray;

    function automatic logic [FIELD_BITS-1:0] to_field(input logic [COUNT_BITS-1:0] v);
        if (COUNT_BITS > FIELD_BITS && 64'(v) > 64'({FIELD_BITS{1'b1}}))
            return {FIELD_BITS{1'b1}};
        return FIELD_BITS'(v);
    endfunction

    function automatic logic span_has(input int pos, input int start, input int len);
        return pos >= start && pos < start + len;
    endfunction

    function automatic void clear_model();
        band_cfg.band_low      = 8'd128;
        band_cfg.band_high     = 8'd255;
        band_cfg.mark_enable   = 1'b0;
        band_cfg.region_enable = 1'b0;
        band_cfg.region_x      = '0;
        band_cfg.region_y      = '0;
        band_cfg.region_width  = SIZE_BITS'(500);
        band_cfg.region_height = SIZE_BITS'(500);
        foreach (bin_tally[i]) bin_tally[i] = '0;
        peak_tally = '0;
    endfunction

    function automatic void apply_reg(input t_cfg_wr w);
        case (t_cfg_idx'(w.index))
            CFG_BAND_LOW:      band_cfg.band_low      = w.data[PIX_BITS-1:0];
            CFG_BAND_HIGH:     band_cfg.band_high     = w.data[PIX_BITS-1:0];
            CFG_MARK_ENABLE:   band_cfg.mark_enable   = w.data[0];
            CFG_REGION_ENABLE: band_cfg.region_enable = w.data[0];
            CFG_REGION_X:      band_cfg.region_x      = w.data[COORD_BITS-1:0];
            CFG_REGION_Y:      band_cfg.region_y      = w.data[COORD_BITS-1:0];
            CFG_REGION_WIDTH:  band_cfg.region_width  = w.data[SIZE_BITS-1:0];
            CFG_REGION_HEIGHT: band_cfg.region_height = w.data[SIZE_BITS-1:0];
            default: ;
        endcase
    endfunction

    // color and count one item, updating the shadow bins and peak
    function automatic t_res shade_and_count(input t_pix it);
        t_res                  r;
        logic                  in_band;
        logic                  in_roi;
        logic [COUNT_BITS-1:0] c;
        r = '0;
        items_seen++;
        if (it.opcode == OP_READ) begin
            // reads leave the state alone, frame_start included
            reads_seen++;
            r.bin_count  = to_field(bin_tally[it.bin_index]);
            r.peak_count = to_field(peak_tally);
            return r;
        end
        if (it.frame_start) begin
            foreach (bin_tally[i]) bin_tally[i] = '0;
            peak_tally = '0;
        end
        in_band = it.gray_level >= band_cfg.band_low && it.gray_level <= band_cfg.band_high;
        in_roi  = !band_cfg.region_enable ||
                  (span_has(int'(it.column), int'(band_cfg.region_x),
                            int'(band_cfg.region_width)) &&
                   span_has(int'(it.row), int'(band_cfg.region_y),
                            int'(band_cfg.region_height)));
        if (band_cfg.mark_enable && in_band && in_roi) begin
            c = bin_tally[it.gray_level];
            if (c != {COUNT_BITS{1'b1}}) c = c + 1'b1;
            bin_tally[it.gray_level] = c;
            if (c > peak_tally) peak_tally = c;
            r.red_out = PIX_MAX;
            r.marked  = 1'b1;
            marks_seen++;
        end else begin
            r.red_out   = it.gray_level;
            r.green_out = it.gray_level;
            r.blue_out  = it.gray_level;
        end
        r.peak_count = to_field(peak_tally);
        if (int'(peak_tally) > top_peak) top_peak = int'(peak_tally);
        return r;
    endfunction

    function automatic t_pix make_pix(input logic op, input int gray, input int col,
                                      input int row, input logic fs, input int bin);
        t_pix p;
        p.opcode      = op;
        p.gray_level  = PIX_BITS'(gray);
        p.column      = COORD_BITS'(col);
        p.row         = COORD_BITS'(row);
        p.frame_start = fs;
        p.bin_index   = BIN_BITS'(bin);
        return p;
    endfunction

    function automatic t_res make_res(input int r, input int g, input int b,
                                      input int m, input int cnt, input int pk);
        t_res v;
        v.red_out    = PIX_BITS'(r);
        v.green_out  = PIX_BITS'(g);
        v.blue_out   = PIX_BITS'(b);
        v.marked     = m[0];
        v.bin_count  = FIELD_BITS'(cnt);
        v.peak_count = FIELD_BITS'(pk);
        return v;
    endfunction

    function automatic void add_reg(input t_cfg_idx idx, input int val);
        t_step s;
        s.is_reg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        s.item    = '0;
        s.typed   = 1'b0;
        s.want    = '0;
        plan.push_back(s);
    endfunction

    function automatic void add_item(input logic op, input int gray, input int col,
                                     input int row, input logic fs, input int bin);
        t_step s;
        s.is_reg  = 1'b0;
        s.reg_idx = CFG_BAND_LOW;
        s.reg_val = 0;
        s.item    = make_pix(op, gray, col, row, fs, bin);
        s.typed   = 1'b0;
        s.want    = '0;
        plan.push_back(s);
    endfunction

    // fixes the expected result of the last item row
    function automatic void pin(input int r, input int g, input int b,
                                input int m, input int cnt, input int pk);
        t_step s;
        s       = plan.pop_back();
        s.typed = 1'b1;
        s.want  = make_res(r, g, b, m, cnt, pk);
        plan.push_back(s);
    endfunction

    // gray levels around the band edges, or anywhere
    function automatic int pick_gray();
        case ($urandom_range(4))
            0:       return int'(band_cfg.band_low) - 1;
            1:       return int'(band_cfg.band_low);
            2:       return int'(band_cfg.band_high);
            3:       return int'(band_cfg.band_high) + 1;
            default: return int'($urandom_range(255));
        endcase
    endfunction

    task automatic send_item(input t_pix it, input logic typed, input t_res want);
        if (cfg_ch.valid) cfg_ch.valid <= 1'b0;
        while (!steady && $urandom_range(99) < 21) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.data  <= it;
        pin_flag     <= typed;
        pin_res      <= want;
        do @(posedge i_clk); while (!pix_ch.ready);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int val);
        t_cfg_wr w;
        w.index = idx;
        w.data  = CFG_DATA_BITS'(val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= w;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic wait_idle();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (rgb_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int p);
        int lo, hi, en, ren, x, y, w, h;
        lo  = $urandom_range(255);
        hi  = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(255, lo);
        en  = 1;
        ren = 1;
        x   = $urandom_range(1) ? $urandom_range(60) : $urandom_range(4095);
        y   = $urandom_range(1) ? $urandom_range(60) : $urandom_range(4095);
        w   = $urandom_range(1, 40);
        h   = $urandom_range(1, 40);
        case (p)
            0: begin lo = 0; hi = 255; ren = 0; end
            2: begin x = 4095; y = 4095; w = 4096; h = 4096; lo = 255; hi = 255; end
            4: begin lo = $urandom_range(1, 255); hi = $urandom_range(lo - 1); end
            5: if ($urandom_range(1)) w = 0; else h = 0;
            6: en = 0;
            7: begin x = 0; y = 0; w = 4096; h = 4096; lo = 0; hi = 0; end
            8: ren = 0;
            default: ;
        endcase
        write_reg(CFG_BAND_LOW, lo);
        write_reg(CFG_BAND_HIGH, hi);
        write_reg(CFG_MARK_ENABLE, en);
        write_reg(CFG_REGION_ENABLE, ren);
        write_reg(CFG_REGION_X, x);
        write_reg(CFG_REGION_Y, y);
        write_reg(CFG_REGION_WIDTH, w);
        write_reg(CFG_REGION_HEIGHT, h);
        settings_used++;
    endtask

    // mostly raster-scanned frames near the region or frame edges or anywhere, some reads and stray pixels
    task automatic random_burst(input int count);
        t_pix it;
        int   pick;
        int   idx;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                it = make_pix(OP_READ, $urandom_range(255), $urandom_range(4095),
                              $urandom_range(4095), 1'($urandom_range(1)), pick_gray());
            end else if (pick < 20) begin
                it = make_pix(OP_PIXEL, pick_gray(), $urandom_range(4095),
                              $urandom_range(4095), $urandom_range(9) == 0,
                              $urandom_range(255));
            end else begin
                if (frame_left == 0) begin
                    frame_w    = $urandom_range(3, 24);
                    frame_pix  = frame_w * $urandom_range(2, 10);
                    frame_left = frame_pix;
                    hot_gray   = pick_gray();
                    case ($urandom_range(3))
                        0: begin
                            frame_x0 = int'(band_cfg.region_x) - $urandom_range(3);
                            frame_y0 = int'(band_cfg.region_y) - $urandom_range(3);
                        end
                        1: begin
                            frame_x0 = int'(band_cfg.region_x) + int'(band_cfg.region_width)
                                       - $urandom_range(1, frame_w);
                            frame_y0 = int'(band_cfg.region_y) + int'(band_cfg.region_height)
                                       - $urandom_range(1, 4);
                        end
                        2: begin
                            frame_x0 = $urandom_range(4095);
                            frame_y0 = $urandom_range(4095);
                        end
                        default: begin
                            frame_x0 = 4096 - $urandom_range(1, frame_w);
                            frame_y0 = 4096 - $urandom_range(1, 4);
                        end
                    endcase
                end
                idx = frame_pix - frame_left;
                it  = make_pix(OP_PIXEL, ($urandom_range(9) < 3) ? hot_gray : pick_gray(),
                               frame_x0 + idx % frame_w, frame_y0 + idx / frame_w,
                               idx == 0, $urandom_range(255));
                frame_left--;
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // model update and result check, all at the clock edge
    always @(posedge i_clk) begin
        t_res want;
        t_res pred;
        t_res got;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.data);
            if (pix_ch.valid && pix_ch.ready) begin
                pred = shade_and_count(pix_ch.data);
                rgb_due.push_back(pin_flag ? pin_res : pred);
            end
            if (res_ch.valid && res_ch.ready) begin
                got = res_ch.data;
                results_seen++;
                if (rgb_due.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d arrived with nothing pending", results_seen);
                end else begin
                    want = rgb_due.pop_front();
                    if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                        got.blue_out !== want.blue_out || got.marked !== want.marked ||
                        got.bin_count !== want.bin_count ||
                        got.peak_count !== want.peak_count) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result %0d: want rgb=%0d,%0d,%0d m=%0d bin=%0d peak=%0d",
                                     results_seen, want.red_out, want.green_out,
                                     want.blue_out, want.marked, want.bin_count,
                                     want.peak_count,
                                     "  got rgb=%0d,%0d,%0d m=%0d bin=%0d peak=%0d",
                                     got.red_out, got.green_out, got.blue_out,
                                     got.marked, got.bin_count, got.peak_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     rgb_due.size());
            $display("tb: failure");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= steady || ($urandom_range(99) >= 21);
        end
    end

    initial begin
        logic prev_reg;
        i_rst_n      <= 1'b0;
        steady       <= 1'b0;
        pin_flag     <= 1'b0;
        pin_res      <= '0;
        pix_ch.valid <= 1'b0;
        pix_ch.data  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        frame_left   = 0;

        // reset defaults: marking off, band 128..255
        add_item(OP_READ, 0, 0, 0, 1'b0, 0);            pin(0, 0, 0, 0, 0, 0);
        add_item(OP_READ, 0, 0, 0, 1'b0, 255);          pin(0, 0, 0, 0, 0, 0);
        add_item(OP_PIXEL, 0, 0, 0, 1'b0, 0);           pin(0, 0, 0, 0, 0, 0);
        add_item(OP_PIXEL, 255, 4095, 4095, 1'b0, 255); pin(255, 255, 255, 0, 0, 0);
        // whole frame marking
        add_reg(CFG_MARK_ENABLE, 1);
        add_item(OP_PIXEL, 128, 7, 3, 1'b1, 0);         pin(255, 0, 0, 1, 0, 1);
        add_item(OP_PIXEL, 127, 8, 3, 1'b0, 0);         pin(127, 127, 127, 0, 0, 1);
        add_item(OP_PIXEL, 255, 9, 3, 1'b0, 0);         pin(255, 0, 0, 1, 0, 1);
        add_item(OP_PIXEL, 255, 10, 3, 1'b0, 0);
        add_item(OP_READ, 0, 0, 0, 1'b0, 255);
        add_item(OP_READ, 0, 0, 0, 1'b1, 128);          // frame_start ignored on reads
        add_item(OP_PIXEL, 10, 0, 0, 1'b1, 0);          pin(10, 10, 10, 0, 0, 0);
        add_item(OP_READ, 0, 0, 0, 1'b0, 255);          pin(0, 0, 0, 0, 0, 0);
        // small region, band 50..60, probe each edge
        add_reg(CFG_REGION_ENABLE, 1);
        add_reg(CFG_REGION_X, 100);
        add_reg(CFG_REGION_Y, 200);
        add_reg(CFG_REGION_WIDTH, 10);
        add_reg(CFG_REGION_HEIGHT, 5);
        add_reg(CFG_BAND_LOW, 50);
        add_reg(CFG_BAND_HIGH, 60);
        add_item(OP_PIXEL, 50, 100, 200, 1'b0, 0);
        add_item(OP_PIXEL, 60, 109, 204, 1'b0, 0);
        add_item(OP_PIXEL, 60, 110, 204, 1'b0, 0);
        add_item(OP_PIXEL, 55, 99, 202, 1'b0, 0);
        add_item(OP_PIXEL, 55, 105, 205, 1'b0, 0);
        add_item(OP_PIXEL, 55, 105, 199, 1'b0, 0);
        add_item(OP_PIXEL, 49, 105, 202, 1'b0, 0);
        add_item(OP_PIXEL, 61, 105, 202, 1'b0, 0);
        // band turned inside out, then a zero-width region
        add_reg(CFG_BAND_LOW, 200);
        add_reg(CFG_BAND_HIGH, 100);
        add_item(OP_PIXEL, 150, 105, 202, 1'b0, 0);
        add_reg(CFG_BAND_LOW, 0);
        add_reg(CFG_BAND_HIGH, 255);
        add_reg(CFG_REGION_WIDTH, 0);
        add_item(OP_PIXEL, 150, 100, 200, 1'b0, 0);
        // one-pixel corner region that runs off the frame
        add_reg(CFG_REGION_X, 4095);
        add_reg(CFG_REGION_Y, 4095);
        add_reg(CFG_REGION_WIDTH, 4096);
        add_reg(CFG_REGION_HEIGHT, 4096);
        add_item(OP_PIXEL, 0, 4095, 4095, 1'b1, 0);     pin(255, 0, 0, 1, 0, 1);
        add_item(OP_PIXEL, 0, 4094, 4095, 1'b0, 0);     pin(0, 0, 0, 0, 0, 1);
        add_item(OP_READ, 0, 0, 0, 1'b0, 0);            pin(0, 0, 0, 0, 1, 1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        prev_reg = 1'b0;
        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (!prev_reg) wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].want);
            end
            prev_reg = plan[i].is_reg;
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            apply_setting(p);
            steady     <= (p == 3);
            frame_left = 0;
            random_burst(PHASE_ITEMS);
        end

        wait_idle();
        $display("covered %0d items: %0d bin reads, %0d marked pixels, %0d random settings",
                 items_seen, reads_seen, marks_seen, settings_used);
        $display("highest peak %0d, %0d results checked, %0d mismatches, %0d cycles",
                 top_peak, results_seen, mismatch_count, cycle_count);
        if (mismatch_count == 0 && rgb_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
